FILE: hw/rtl/bdlr_pkg.sv
// Shared types and codes for the debounced button with long-release detection.
// No dependencies; used by every bdlr module and the top level.
`default_nettype none

package bdlr_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned BounceW = 16;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 32;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_LONG    = 2'd3
  } bdlr_event_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BOUNCE_MS       = 8'd0,
    REG_LONG_RELEASE_MS = 8'd1,
    REG_LONG_RELEASE_EN = 8'd2,
    REG_PULL_UP         = 8'd3
  } bdlr_reg_e;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             raw_level;
    logic             latched_pending;
    logic             latched_level;
    logic             disabled;
  } bdlr_poll_t;

  typedef struct packed {
    bdlr_event_e event_res;
    logic        pressed;
  } bdlr_result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgDatW-1:0] data;
  } bdlr_cfg_wr_t;

  // Current register values, handed from the register file to the step logic.
  typedef struct packed {
    logic [BounceW-1:0] bounce_ms;
    logic [TimeW-1:0]   long_release_ms;
    logic               long_release_enable;
    logic               pull_up;
  } bdlr_cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bdlr_chan_if.sv
// Valid/ready channel carrying one packed payload per transfer.
// Payload type is supplied by the user, normally from bdlr_pkg.
`default_nettype none

interface bdlr_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bdlr_cfg_regs.sv
// Configuration register file for the button debouncer.
// Depends on bdlr_pkg and bdlr_chan_if.
`default_nettype none

module bdlr_cfg_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  bdlr_chan_if.sink          cfg_i,
  output bdlr_pkg::bdlr_cfg_t cfg_o
);
  import bdlr_pkg::*;

  bdlr_cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.payload.index)
        REG_BOUNCE_MS:       cfg_d.bounce_ms = cfg_i.payload.data[BounceW-1:0];
        REG_LONG_RELEASE_MS: cfg_d.long_release_ms = cfg_i.payload.data[TimeW-1:0];
        REG_LONG_RELEASE_EN: cfg_d.long_release_enable = cfg_i.payload.data[0];
        REG_PULL_UP:         cfg_d.pull_up = cfg_i.payload.data[0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bounce_ms           <= BounceW'(50);
      cfg_q.long_release_ms     <= TimeW'(500);
      cfg_q.long_release_enable <= 1'b0;
      cfg_q.pull_up             <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hw/rtl/bdlr_step.sv
// Debounce state and single-poll update logic.
// Depends on bdlr_pkg.
`default_nettype none

module bdlr_step (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                advance_i,
  input  wire bdlr_pkg::bdlr_cfg_t  cfg_i,
  input  wire bdlr_pkg::bdlr_poll_t poll_i,
  output bdlr_pkg::bdlr_result_t   result_o
);
  import bdlr_pkg::*;

  logic             started_q, started_d;
  logic             stable_q, stable_d;
  logic             last_q, last_d;
  logic             was_dis_q, was_dis_d;
  logic [TimeW-1:0] bounce_start_q, bounce_start_d;
  logic [TimeW-1:0] hold_start_q, hold_start_d;

  logic             stable_eff, last_eff, level, new_pressed;
  logic [TimeW-1:0] bounce_elapsed, hold_elapsed;
  bdlr_event_e      ev;

  always_comb begin
    // first poll after reset seeds both levels from the raw pin
    stable_eff = started_q ? stable_q : poll_i.raw_level;
    last_eff   = started_q ? last_q   : poll_i.raw_level;
    level      = poll_i.latched_pending ? poll_i.latched_level : poll_i.raw_level;

    started_d      = 1'b1;
    stable_d       = stable_eff;
    last_d         = last_eff;
    was_dis_d      = was_dis_q;
    bounce_start_d = bounce_start_q;
    hold_start_d   = hold_start_q;
    ev             = EV_NONE;

    bounce_elapsed = '0;
    hold_elapsed   = poll_i.now_ms - hold_start_q;
    new_pressed    = cfg_i.pull_up ? ~level : level;

    priority if (poll_i.disabled) begin
      was_dis_d = 1'b1;
    end else if (was_dis_q) begin
      // resync after suspension, no event
      was_dis_d      = 1'b0;
      stable_d       = level;
      last_d         = level;
      bounce_start_d = poll_i.now_ms;
      hold_start_d   = poll_i.now_ms;
    end else begin
      if (level != last_eff) begin
        bounce_start_d = poll_i.now_ms;
      end
      last_d         = level;
      bounce_elapsed = poll_i.now_ms - bounce_start_d;
      if ((bounce_elapsed >= TimeW'(cfg_i.bounce_ms)) && (level != stable_eff)) begin
        stable_d = level;
        if (new_pressed) begin
          hold_start_d = poll_i.now_ms;
          ev           = EV_PRESS;
        end else if (cfg_i.long_release_enable &&
                     (hold_elapsed >= cfg_i.long_release_ms)) begin
          ev = EV_LONG;
        end else begin
          ev = EV_RELEASE;
        end
      end
    end

    result_o.event_res = ev;
    result_o.pressed   = cfg_i.pull_up ? ~stable_d : stable_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q      <= 1'b0;
      stable_q       <= 1'b0;
      last_q         <= 1'b0;
      was_dis_q      <= 1'b0;
      bounce_start_q <= '0;
      hold_start_q   <= '0;
    end else if (advance_i) begin
      started_q      <= started_d;
      stable_q       <= stable_d;
      last_q         <= last_d;
      was_dis_q      <= was_dis_d;
      bounce_start_q <= bounce_start_d;
      hold_start_q   <= hold_start_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/button_debounce_long_release.sv
// Top level: debounced push button with press, release and long-release events.
// Depends on bdlr_pkg, bdlr_chan_if, bdlr_cfg_regs and bdlr_step.
//
//   channel    dir   payload           one transfer is
//   ---------  ----  ----------------  --------------------------------------
//   poll_i     in    bdlr_poll_t       one poll: timestamp, levels, disable
//   result_o   out   bdlr_result_t     event code and debounced pressed state
//   cfg_i      in    bdlr_cfg_wr_t     one register write (index, data)
//
// Two register stages: an input register and a result register, with the
// whole poll update (two 32-bit subtract-compares) between them.
// Throughput is one poll per cycle while result_o is not stalled; a poll is
// captured in the input register, its result in the result register, which
// drives result_o.valid. Reset clears the debounce state and loads register
// defaults (bounce 50 ms, long release 500 ms, long release off, pull-up).
// A stalled result holds the result register; the input register then holds
// one more poll, after which poll_i.ready drops until result_o drains.
`default_nettype none

module button_debounce_long_release (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bdlr_chan_if.sink   poll_i,
  bdlr_chan_if.source result_o,
  bdlr_chan_if.sink   cfg_i
);
  import bdlr_pkg::*;

  bdlr_cfg_t    cfg;
  bdlr_poll_t   poll_q;
  bdlr_result_t result_d, result_q;
  logic         in_valid_q, out_valid_q;
  logic         advance, poll_xfer;

  // input stage moves into the result stage when the result slot is free
  assign advance       = in_valid_q && (!out_valid_q || result_o.ready);
  assign poll_i.ready  = !in_valid_q || advance;
  assign poll_xfer     = poll_i.valid && poll_i.ready;

  bdlr_cfg_regs u_cfg (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_i),
    .cfg_o (cfg)
  );

  bdlr_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .cfg_i    (cfg),
    .poll_i   (poll_q),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (poll_i.ready) begin
        in_valid_q <= poll_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (poll_xfer) begin
      poll_q <= poll_i.payload;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = result_q;

  // a press always leaves the button pressed, a release always released
  a_press_pressed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.payload.event_res == EV_PRESS))
      |-> result_o.payload.pressed)
    else $error("press event with pressed low");

  a_release_released : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && ((result_o.payload.event_res == EV_RELEASE) ||
                        (result_o.payload.event_res == EV_LONG)))
      |-> !result_o.payload.pressed)
    else $error("release event with pressed high");

  // long releases only come out of a step taken with the feature enabled
  a_long_needs_enable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (result_d.event_res == EV_LONG)) |-> cfg.long_release_enable)
    else $error("long release while disabled");

  // an accepted poll always lands in the input stage
  a_poll_captured : assert property (@(posedge clk_i) disable iff (!rst_ni)
    poll_xfer |=> in_valid_q)
    else $error("accepted poll lost");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for button_debounce_long_release: polls, results, register writes.
// Needs bdlr_pkg and bdlr_chan_if from the RTL; predicts every poll's event in a
// small tracker class.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bdlr_pkg::*;

  // Run guard, in clock cycles.
  localparam int unsigned CycleLimit = 400000;

  // Debounce tracker: its own copy of the registers and button state.
  // It predicts one result per accepted poll and compares the results in order.
  class debounce_tracker;
    logic [BounceW-1:0] bounce_ms;
    logic [TimeW-1:0]   long_ms;
    logic               long_en;
    logic               pull_up;

    logic               started;
    logic               stable_lvl;
    logic               last_lvl;
    logic               was_off;
    logic [TimeW-1:0]   bounce_t0;
    logic [TimeW-1:0]   hold_t0;

    bdlr_result_t       due_results[$];
    int unsigned        errors;
    int unsigned        presses;
    int unsigned        releases;
    int unsigned        longs;

    function new();
      bounce_ms  = 16'd50;
      long_ms    = 32'd500;
      long_en    = 1'b0;
      pull_up    = 1'b1;
      started    = 1'b0;
      stable_lvl = 1'b0;
      last_lvl   = 1'b0;
      was_off    = 1'b0;
      bounce_t0  = '0;
      hold_t0    = '0;
      errors     = 0;
      presses    = 0;
      releases   = 0;
      longs      = 0;
    endfunction

    function logic pressed_now();
      return pull_up ? ~stable_lvl : stable_lvl;
    endfunction

    function void set_reg(bdlr_reg_e idx, logic [CfgDatW-1:0] val);
      case (idx)
        REG_BOUNCE_MS:       bounce_ms = val[BounceW-1:0];
        REG_LONG_RELEASE_MS: long_ms   = val[TimeW-1:0];
        REG_LONG_RELEASE_EN: long_en   = val[0];
        REG_PULL_UP:         pull_up   = val[0];
        default: ;
      endcase
    endfunction

    function void take_poll(bdlr_poll_t p);
      logic             lvl;
      logic [TimeW-1:0] since_edge;
      logic [TimeW-1:0] held;
      bdlr_event_e      ev;
      bdlr_result_t     r;
      ev = EV_NONE;
      // first poll after reset seeds both levels from the raw pin
      if (!started) begin
        stable_lvl = p.raw_level;
        last_lvl   = p.raw_level;
        started    = 1'b1;
      end
      lvl = p.latched_pending ? p.latched_level : p.raw_level;
      if (p.disabled) begin
        was_off = 1'b1;
      end else if (was_off) begin
        // resync on the first enabled poll, no event
        was_off    = 1'b0;
        stable_lvl = lvl;
        last_lvl   = lvl;
        bounce_t0  = p.now_ms;
        hold_t0    = p.now_ms;
      end else begin
        if (lvl != last_lvl) bounce_t0 = p.now_ms;
        last_lvl   = lvl;
        since_edge = p.now_ms - bounce_t0;
        if (since_edge >= {16'd0, bounce_ms} && lvl != stable_lvl) begin
          stable_lvl = lvl;
          held       = p.now_ms - hold_t0;
          if (pressed_now()) begin
            hold_t0 = p.now_ms;
            ev      = EV_PRESS;
          end else if (long_en && held >= long_ms) begin
            ev = EV_LONG;
          end else begin
            ev = EV_RELEASE;
          end
        end
      end
      r.event_res = ev;
      r.pressed   = pressed_now();
      due_results.push_back(r);
    endfunction

    function void check_result(bdlr_result_t got);
      bdlr_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result with no poll outstanding: expected none, actual event %0d pressed %0b",
                 $time, got.event_res, got.pressed);
        return;
      end
      want = due_results.pop_front();
      if (got.event_res !== want.event_res) begin
        errors++;
        $display("%0t: event_res mismatch: expected %0d, actual %0d",
                 $time, want.event_res, got.event_res);
      end
      if (got.pressed !== want.pressed) begin
        errors++;
        $display("%0t: pressed mismatch: expected %0b, actual %0b",
                 $time, want.pressed, got.pressed);
      end
      case (want.event_res)
        EV_PRESS:   presses++;
        EV_RELEASE: releases++;
        EV_LONG:    longs++;
        default: ;
      endcase
    endfunction

    function int unsigned waiting();
      return due_results.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5ns clk = ~clk;

  bdlr_chan_if #(.payload_t(bdlr_poll_t))   poll_ch ();
  bdlr_chan_if #(.payload_t(bdlr_result_t)) res_ch  ();
  bdlr_chan_if #(.payload_t(bdlr_cfg_wr_t)) cfg_ch  ();

  button_debounce_long_release u_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .poll_i   (poll_ch),
    .result_o (res_ch),
    .cfg_i    (cfg_ch)
  );

  debounce_tracker board = new();

  // Stimulus-side state: the poll clock in ms, the level the button is
  // heading for, and the no-stall flag for the quiet stretch.
  logic [TimeW-1:0] ms_now;
  logic             goal;
  logic             quiet = 1'b0;
  int unsigned      hold_span;
  int unsigned      polls_sent   = 0;
  int unsigned      cfg_writes   = 0;
  int unsigned      cycles       = 0;

  // ---------------------------------------------------------------------------
  // Result side: ready toggles at the falling edge, transfers are checked at
  // the rising edge. Ready is held high throughout the quiet stretch.
  // ---------------------------------------------------------------------------
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= quiet || ($urandom_range(0, 99) >= 30);
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) board.check_result(res_ch.payload);
  end

  // Run guard: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d results still due",
               $time, cycles, board.waiting());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task is entered at a falling edge and returns at one.
  // Valid is left high after a transfer so back-to-back polls never see a
  // low/high pair of assignments in one time step.
  // ---------------------------------------------------------------------------
  function automatic bdlr_poll_t poll_of(logic [TimeW-1:0] t, logic raw, logic pend,
                                         logic lat, logic off);
    bdlr_poll_t p;
    p.now_ms          = t;
    p.raw_level       = raw;
    p.latched_pending = pend;
    p.latched_level   = lat;
    p.disabled        = off;
    return p;
  endfunction

  task automatic send_poll(input bdlr_poll_t p);
    // random gaps before the poll, none in the quiet stretch
    while (!quiet && $urandom_range(0, 99) < 30) begin
      poll_ch.valid <= 1'b0;
      @(negedge clk);
    end
    poll_ch.valid   <= 1'b1;
    poll_ch.payload <= p;
    do @(posedge clk); while (!poll_ch.ready);
    board.take_poll(p);
    polls_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input bdlr_reg_e idx, input logic [CfgDatW-1:0] val);
    bdlr_cfg_wr_t w;
    w.index = idx;
    w.data  = val;
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    board.set_reg(idx, val);
    cfg_writes++;
    @(negedge clk);
  endtask

  // Hold off polls until every predicted result has come back, then idle on so the
  // two-stage pipe can show any stray result.
  task automatic drain();
    poll_ch.valid <= 1'b0;
    while (board.waiting() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Only called on an idle block (after reset or after drain).
  task automatic configure(input logic [BounceW-1:0] bnc, input logic [TimeW-1:0] lng,
                           input logic en, input logic pu);
    write_reg(REG_BOUNCE_MS, {16'd0, bnc});
    write_reg(REG_LONG_RELEASE_MS, lng);
    write_reg(REG_LONG_RELEASE_EN, {31'd0, en});
    write_reg(REG_PULL_UP, {31'd0, pu});
    cfg_ch.valid <= 1'b0;
    // span for the occasional long hold between press and release
    hold_span = (lng > 32'h7FFF_FFF0) ? 32'hFFFF_FFFF : lng * 2 + 10;
  endtask

  // One poll at the current ms clock. A fifth of them carry the level in the
  // latched slot with a random raw pin, so the override path sees real traffic.
  task automatic poll_level(input logic lvl);
    logic off;
    logic pend;
    bdlr_poll_t p;
    off  = ($urandom_range(0, 99) < 3);
    pend = ($urandom_range(0, 4) == 0);
    if (pend) p = poll_of(ms_now, 1'($urandom_range(0, 1)), 1'b1, lvl, off);
    else      p = poll_of(ms_now, lvl, 1'b0, 1'($urandom_range(0, 1)), off);
    send_poll(p);
  endtask

  // Time step for a settled poll: mostly around the bounce window, now and
  // then long enough to cross the long-release limit.
  function automatic int unsigned settle_step(int unsigned b);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, b);
    if (r < 8) return $urandom_range(b, b * 2 + 1);
    return $urandom_range(0, hold_span);
  endfunction

  // Random traffic: mostly press/release episodes (a short bounce burst, then
  // a settled level), plus fully random noise polls and rare big time jumps.
  task automatic random_polls(input int unsigned n);
    int unsigned sent;
    int unsigned b;
    int unsigned r;
    sent = 0;
    b    = board.bounce_ms;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_poll(poll_of($urandom(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        sent++;
      end else begin
        if ($urandom_range(0, 4) != 0) goal = ~goal;
        repeat ($urandom_range(0, 4)) begin
          ms_now += $urandom_range(0, b / 4 + 1);
          poll_level(1'($urandom_range(0, 1)));
          sent++;
        end
        repeat ($urandom_range(1, 5)) begin
          ms_now += settle_step(b);
          poll_level(goal);
          sent++;
        end
        if (r >= 96) ms_now += $urandom();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    poll_ch.valid   <= 1'b0;
    poll_ch.payload <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.payload  <= '0;
    ms_now    = '0;
    goal      = 1'b0;
    hold_span = 1010;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset defaults: 50 ms bounce, 500 ms long limit, long off, pull-up.
    // Very first poll: latched level disagrees with the raw pin.
    send_poll(poll_of(32'd100, 1'b0, 1'b1, 1'b1, 1'b0));
    send_poll(poll_of(32'd120, 1'b1, 1'b0, 1'b0, 1'b0));
    send_poll(poll_of(32'd160, 1'b1, 1'b0, 1'b0, 1'b0));   // settles high: release
    send_poll(poll_of(32'd170, 1'b0, 1'b0, 1'b1, 1'b0));   // bounce
    send_poll(poll_of(32'd175, 1'b1, 1'b0, 1'b0, 1'b0));
    send_poll(poll_of(32'd180, 1'b0, 1'b0, 1'b0, 1'b0));
    send_poll(poll_of(32'd240, 1'b0, 1'b0, 1'b1, 1'b0));   // press
    send_poll(poll_of(32'd900, 1'b1, 1'b0, 1'b0, 1'b0));
    send_poll(poll_of(32'd960, 1'b1, 1'b0, 1'b0, 1'b0));   // long hold, but long off
    send_poll(poll_of(32'd1000, 1'b0, 1'b0, 1'b0, 1'b1));  // disabled
    send_poll(poll_of(32'd1010, 1'b1, 1'b1, 1'b0, 1'b1));
    send_poll(poll_of(32'd1020, 1'b0, 1'b0, 1'b0, 1'b0));  // resync, no event
    send_poll(poll_of(32'd1100, 1'b0, 1'b1, 1'b1, 1'b0));  // latched overrides raw
    send_poll(poll_of(32'd1200, 1'b1, 1'b0, 1'b0, 1'b0));
    // timestamp wrap through all-ones
    send_poll(poll_of(32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_poll(poll_of(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0));
    send_poll(poll_of(32'h0000_0030, 1'b0, 1'b0, 1'b0, 1'b0));
    ms_now = 32'h0000_0030;
    random_polls(150);

    // Zero bounce, zero long limit, long on, pull-down: accept at once and
    // every release is long.
    drain();
    configure(16'd0, 32'd0, 1'b1, 1'b0);
    send_poll(poll_of(32'h40, 1'b1, 1'b0, 1'b0, 1'b0));
    send_poll(poll_of(32'h40, 1'b0, 1'b0, 1'b1, 1'b0));
    send_poll(poll_of(32'h41, 1'b1, 1'b1, 1'b0, 1'b0));
    ms_now = 32'h41;
    random_polls(200);

    // Full-scale bounce and long limit: the window edge at exactly 65535 ms.
    drain();
    configure(16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_poll(poll_of(32'd1000, 1'b1, 1'b0, 1'b0, 1'b0));
    send_poll(poll_of(32'd1000 + 32'd65534, 1'b1, 1'b0, 1'b0, 1'b0));
    send_poll(poll_of(32'd1000 + 32'd65535, 1'b1, 1'b0, 1'b0, 1'b0));
    ms_now = 32'd1000 + 32'd65535;
    random_polls(250);

    // Defaults with long release on, both sides streaming without stalls.
    drain();
    configure(16'd50, 32'd500, 1'b1, 1'b1);
    quiet = 1'b1;
    random_polls(250);
    quiet = 1'b0;

    drain();
    configure(16'($urandom_range(0, 200)), $urandom_range(0, 3000), 1'b1,
              1'($urandom_range(0, 1)));
    random_polls(250);

    // Anything goes across the whole register range.
    drain();
    configure(16'($urandom_range(0, 65535)), $urandom(), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
    random_polls(150);

    drain();
    configure(16'd20, 32'd100, 1'b0, 1'b0);
    random_polls(250);

    drain();

    $display("Ran %0d polls and %0d register writes over seven register settings.",
             polls_sent, cfg_writes);
    $display("Saw %0d presses, %0d releases, %0d long releases; %0d mismatches.",
             board.presses, board.releases, board.longs, board.errors);
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
